FILE: design/multi_stack_shared_pool_top_macros.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef MULTI_STACK_SHARED_POOL_TOP_MACROS_SVH
`define MULTI_STACK_SHARED_POOL_TOP_MACROS_SVH

`ifndef SYNTH
`define MSP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define MSP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MSP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define MSP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/msp_pkg.sv
package msp_pkg;

    localparam int ValueW  = 32;
    localparam int SidW    = 2;
    localparam int StatusW = 2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [StatusW-1:0] ST_OK    = 2'd0;
    localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
    localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [StatusW-1:0]       status;
        logic signed [ValueW-1:0] popped_value;
    } t_resp;

endpackage

FILE: design/msp_if.sv
interface msp_req_if
    import msp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [SidW-1:0]          stack_id;
    logic signed [ValueW-1:0] value;

    modport source (output valid, output func, output stack_id, output value, input ready);
    modport sink (input valid, input func, input stack_id, input value, output ready);
endinterface

interface msp_resp_if
    import msp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] popped_value;

    modport source (output valid, output status, output popped_value, input ready);
    modport sink (input valid, input status, input popped_value, output ready);
endinterface

FILE: design/multi_stack_shared_pool_top.sv
// Channel   Dir  Modport  Payload
// i_req     in   sink     func, stack_id, value
// o_resp    out  source   status, popped_value
//
// A request is accepted in the idle state, which reads the link and data
// memories; the execute state then writes them back and loads the result
// register, and it waits while the result register is still occupied.
// Reset is synchronous and needs no clearing pass; link entries at or above the
// high-water mark read as the initial free chain.
`include "multi_stack_shared_pool_top_macros.svh"

module multi_stack_shared_pool_top
    import msp_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int POOL_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msp_req_if.sink    i_req,
    msp_resp_if.source o_resp
);
    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int TW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LW-1:0] NilCode = LW'(POOL_DEPTH);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                   r_state;
    logic [LW-1:0]            r_top [NUM_STACKS];
    logic [LW-1:0]            r_free_head;
    logic [LW-1:0]            r_hwm;
    logic                     r_func;
    logic [TW-1:0]            r_tidx;
    logic [LW-1:0]            r_slot;
    logic                     r_slot_ok;
    logic signed [ValueW-1:0] r_value;

    logic                     in_fire;
    logic                     sid_ok;
    logic [TW-1:0]            tidx;
    logic [LW-1:0]            top_cur;
    logic [LW-1:0]            slot;
    logic                     out_can_load;
    logic                     exec_go;
    logic                     do_write;
    logic [LW-1:0]            link_rdata;
    logic [LW-1:0]            link_next;
    logic [LW-1:0]            link_wdata;
    logic [ValueW-1:0]        data_rdata;
    logic [LW-1:0]            n_free_head;
    logic [LW-1:0]            n_hwm;
    logic [LW-1:0]            n_top;
    t_resp                    resp;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;

    assign sid_ok  = int'(i_req.stack_id) < NUM_STACKS;
    assign tidx    = TW'(i_req.stack_id);
    assign top_cur = sid_ok ? r_top[tidx] : NilCode;
    assign slot    = (i_req.func == FUNC_POP) ? top_cur : r_free_head;

    assign exec_go  = (r_state == S_EXEC) && out_can_load;
    assign do_write = exec_go && r_slot_ok;

    assign link_next  = (r_slot < r_hwm) ? link_rdata : r_slot + LW'(1);
    assign link_wdata = (r_func == FUNC_PUSH) ? r_top[r_tidx] : r_free_head;

    always_comb begin
        n_free_head = r_free_head;
        n_hwm       = r_hwm;
        n_top       = r_top[r_tidx];
        if (r_func == FUNC_PUSH) begin
            n_free_head = link_next;
            n_top       = r_slot;
            if (r_slot == r_hwm) begin
                n_hwm = r_hwm + LW'(1);
            end
        end else begin
            n_free_head = r_slot;
            n_top       = link_next;
        end
    end

    always_comb begin
        resp.popped_value = '0;
        if (r_slot_ok) begin
            resp.status = ST_OK;
            if (r_func == FUNC_POP) begin
                resp.popped_value = data_rdata;
            end
        end else if (r_func == FUNC_POP) begin
            resp.status = ST_EMPTY;
        end else begin
            resp.status = ST_FULL;
        end
    end

    msp_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_slot[AW-1:0]),
        .i_wdata (link_wdata),
        .i_re    (in_fire),
        .i_raddr (slot[AW-1:0]),
        .o_rdata (link_rdata)
    );

    msp_ram #(
        .WIDTH (ValueW),
        .DEPTH (POOL_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (do_write && (r_func == FUNC_PUSH)),
        .i_waddr (r_slot[AW-1:0]),
        .i_wdata (r_value),
        .i_re    (in_fire),
        .i_raddr (slot[AW-1:0]),
        .o_rdata (data_rdata)
    );

    msp_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (exec_go),
        .i_data     (resp),
        .o_can_load (out_can_load),
        .o_resp     (o_resp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_hwm       <= '0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_top[i] <= NilCode;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (do_write) begin
                r_free_head   <= n_free_head;
                r_hwm         <= n_hwm;
                r_top[r_tidx] <= n_top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func    <= i_req.func;
            r_tidx    <= tidx;
            r_slot    <= slot;
            r_slot_ok <= sid_ok && (slot < NilCode);
            r_value   <= i_req.value;
        end
    end

    `MSP_ASSERT_NXT(a_accept_enters_exec, i_clk, i_rst_n, in_fire, r_state == S_EXEC)
    `MSP_ASSERT_NXT(a_exec_loads_result, i_clk, i_rst_n, exec_go, o_resp.valid)
    `MSP_ASSERT_IMP(a_free_head_region, i_clk, i_rst_n, r_free_head >= r_hwm, (r_free_head == r_hwm) || (r_free_head == NilCode))
endmodule

FILE: design/msp_ram.sv
module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/msp_out_stage.sv
module msp_out_stage
    import msp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  t_resp          i_data,
    output logic           o_can_load,
    msp_resp_if.source     o_resp
);
    logic  r_valid;
    t_resp r_data;

    assign o_can_load = !r_valid || o_resp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_resp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_resp.valid        = r_valid;
    assign o_resp.status       = r_data.status;
    assign o_resp.popped_value = r_data.popped_value;
endmodule
